### hdl/rational_number_alu_unit_assert.svh
// Assertion macros for the rational number ALU.
`ifndef RATIONAL_NUMBER_ALU_UNIT_ASSERT_SVH
`define RATIONAL_NUMBER_ALU_UNIT_ASSERT_SVH
// Implication checked every clock, disabled in reset.
`define RNA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define RNA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/rna_pkg.sv
// Shared types and constants for the rational number ALU.
`timescale 1ns / 1ps
package rna_pkg;
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 2 * WORD_BITS;

    localparam logic [2:0] OP_NORM = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_CMP  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef logic [MAG_BITS-1:0] mag_t;
endpackage

### hdl/rational_number_alu_unit.sv
// Rational number ALU top level: sequencer, shared multiplier and divider.
//
// Usage: drive req_type and the four operands with start high while busy is
// low; that edge takes the request beat. busy stays high until the result is
// shown. The result beat appears on res_num, res_den, the compare flags and
// status for exactly one cycle with done high; the receiver cannot stall it.
// A zero denominator or an unused code goes from the check straight to the
// output; compare first runs the three cross products and the combine.
// Normalize runs Euclid steps, then divides both terms by the gcd; the other
// arithmetic ops first form the three cross products and the combine. Each
// Euclid step is one check state plus a 64-bit restoring division.
// The step count (at most about 93 for 64-bit values) sets the rate. busy is
// low in the cycle done is high, so the next beat can be taken there.
// A single 32x32 multiplier forms all cross products, one per cycle.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done and busy; no request is in flight after reset.
`timescale 1ns / 1ps
`include "rational_number_alu_unit_assert.svh"
module rational_number_alu_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        done,
    output logic signed [31:0] res_num,
    output logic [30:0] res_den,
    output logic        is_less,
    output logic        is_equal,
    output logic        is_greater,
    output logic [1:0]  status
);
    localparam int W = rna_pkg::WORD_BITS;
    localparam int M = rna_pkg::MAG_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_M0   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_COMB = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_GDIV = 4'd7;
    localparam logic [3:0] S_RN   = 4'd8;
    localparam logic [3:0] S_RD   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;   // magnitudes
    logic an_neg_reg, bn_neg_reg;
    rna_pkg::mag_t p0_reg, p1_reg, p2_reg;
    rna_pkg::mag_t num_reg, den_reg, gx_reg, gy_reg;
    logic num_neg_reg;
    logic [1:0] st_reg;
    logic lt_reg, eq_reg, gt_reg;

    // shared multiplier operands
    logic [W-1:0] mul_a, mul_b;
    rna_pkg::mag_t mul_p;

    // shared restoring divider
    rna_pkg::mag_t dv_q_reg, dv_r_reg, dv_d_reg;
    logic [6:0] dv_cnt_reg;
    logic dv_run_reg;
    logic dv_go;
    rna_pkg::mag_t dv_n_in, dv_d_in;
    logic [M:0] dv_trial;
    rna_pkg::mag_t dv_rs;

    logic done_reg;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign mul_p = rna_pkg::mag_t'(mul_a) * rna_pkg::mag_t'(mul_b);

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            S_M0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == rna_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            S_M1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            S_M2:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == rna_pkg::OP_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    // divider start and operands
    always_comb
    begin
        dv_go   = 1'b0;
        dv_n_in = gx_reg;
        dv_d_in = gy_reg;
        case (state_reg)
            S_GCD:
            begin
                dv_go   = (gy_reg != '0);
                dv_n_in = gx_reg;
                dv_d_in = gy_reg;
            end
            S_RN:
            begin
                dv_go   = !dv_run_reg;
                dv_n_in = num_reg;
                dv_d_in = gx_reg;
            end
            S_RD:
            begin
                dv_go   = !dv_run_reg;
                dv_n_in = den_reg;
                dv_d_in = gx_reg;
            end
            default:
            begin
                dv_go = 1'b0;
            end
        endcase
    end

    assign dv_rs    = {dv_r_reg[M-2:0], dv_q_reg[M-1]};
    assign dv_trial = {dv_r_reg, dv_q_reg[M-1]} - {1'b0, dv_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_run_reg <= 1'b0;
            dv_cnt_reg <= '0;
        end
        else if (dv_go && !dv_run_reg)
        begin
            dv_run_reg <= 1'b1;
            dv_cnt_reg <= 7'(M);
        end
        else if (dv_run_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
            if (dv_cnt_reg == 7'd1)
            begin
                dv_run_reg <= 1'b0;
            end
        end
    end

    // one quotient bit per cycle; remainder may need M+1 bits transiently
    always_ff @(posedge clk)
    begin
        if (dv_go && !dv_run_reg)
        begin
            dv_q_reg <= dv_n_in;
            dv_r_reg <= '0;
            dv_d_reg <= dv_d_in;
        end
        else if (dv_run_reg)
        begin
            if (!dv_trial[M])
            begin
                dv_r_reg <= dv_trial[M-1:0];
                dv_q_reg <= {dv_q_reg[M-2:0], 1'b1};
            end
            else
            begin
                dv_r_reg <= dv_rs;
                dv_q_reg <= {dv_q_reg[M-2:0], 1'b0};
            end
        end
    end

    logic dv_fin;
    assign dv_fin = dv_run_reg && (dv_cnt_reg == 7'd1);
    // values as they will be after the final step
    rna_pkg::mag_t dv_q_fin, dv_r_fin;
    always_comb
    begin
        if (!dv_trial[M])
        begin
            dv_r_fin = dv_trial[M-1:0];
            dv_q_fin = {dv_q_reg[M-2:0], 1'b1};
        end
        else
        begin
            dv_r_fin = dv_rs;
            dv_q_fin = {dv_q_reg[M-2:0], 1'b0};
        end
    end

    logic [W-1:0] lim;
    assign lim = {1'b0, {(W-1){1'b1}}};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_CHK;
            S_CHK:
            begin
                if (op_reg > rna_pkg::OP_CMP || ad_reg == '0
                    || (op_reg != rna_pkg::OP_NORM && bd_reg == '0)
                    || (op_reg == rna_pkg::OP_DIV && bn_reg == '0))
                    state_next = S_OUT;
                else if (op_reg == rna_pkg::OP_NORM)
                    state_next = S_GCD;
                else
                    state_next = S_M0;
            end
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_COMB;
            S_COMB: state_next = (op_reg == rna_pkg::OP_CMP) ? S_OUT : S_GCD;
            S_GCD:  state_next = (gy_reg == '0) ? S_RN : S_GDIV;
            S_GDIV: if (dv_fin) state_next = S_GCD;
            S_RN:   if (dv_fin) state_next = S_RD;
            S_RD:   if (dv_fin) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
        end
    end

    rna_pkg::mag_t sx, sy;
    logic sxn, syn;
    always_comb
    begin
        sx  = p0_reg;
        sxn = an_neg_reg && (p0_reg != '0);
        sy  = p1_reg;
        syn = ((op_reg == rna_pkg::OP_SUB) ? !bn_neg_reg : bn_neg_reg) && (p1_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= req_type;
                an_reg <= mag_of(a_num[W-1:0]);
                ad_reg <= mag_of(a_den[W-1:0]);
                bn_reg <= mag_of(b_num[W-1:0]);
                bd_reg <= mag_of(b_den[W-1:0]);
                an_neg_reg <= a_num[W-1] ^ a_den[W-1];
                bn_neg_reg <= b_num[W-1] ^ b_den[W-1];
                st_reg <= rna_pkg::ST_OK;
                lt_reg <= 1'b0;
                eq_reg <= 1'b0;
                gt_reg <= 1'b0;
                num_reg <= '0;
                den_reg <= '0;
            end
            S_CHK:
            begin
                if (op_reg > rna_pkg::OP_CMP)
                    st_reg <= rna_pkg::ST_OK;
                else if (ad_reg == '0 || (op_reg != rna_pkg::OP_NORM && bd_reg == '0)
                         || (op_reg == rna_pkg::OP_DIV && bn_reg == '0))
                    st_reg <= rna_pkg::ST_ZERO;
                num_reg     <= rna_pkg::mag_t'(an_reg);
                num_neg_reg <= an_neg_reg && (an_reg != '0);
                den_reg     <= rna_pkg::mag_t'(ad_reg);
                gx_reg      <= rna_pkg::mag_t'(an_reg);
                gy_reg      <= rna_pkg::mag_t'(ad_reg);
            end
            S_M0: p0_reg <= mul_p;
            S_M1: p1_reg <= mul_p;
            S_M2: p2_reg <= mul_p;
            S_COMB:
            begin
                den_reg <= p2_reg;
                gy_reg  <= p2_reg;
                if (op_reg == rna_pkg::OP_CMP)
                begin
                    if (sxn != syn)
                    begin
                        lt_reg <= sxn;
                        gt_reg <= !sxn;
                    end
                    else if (sx == sy)
                        eq_reg <= 1'b1;
                    else
                    begin
                        lt_reg <= (sx < sy) ^ sxn;
                        gt_reg <= !((sx < sy) ^ sxn);
                    end
                end
                else if (op_reg == rna_pkg::OP_MUL || op_reg == rna_pkg::OP_DIV)
                begin
                    num_reg     <= p0_reg;
                    gx_reg      <= p0_reg;
                    num_neg_reg <= (an_neg_reg != bn_neg_reg) && (p0_reg != '0);
                end
                else if (sxn == syn)
                begin
                    num_reg     <= sx + sy;
                    gx_reg      <= sx + sy;
                    num_neg_reg <= sxn;
                end
                else if (sx >= sy)
                begin
                    num_reg     <= sx - sy;
                    gx_reg      <= sx - sy;
                    num_neg_reg <= sxn && (sx != sy);
                end
                else
                begin
                    num_reg     <= sy - sx;
                    gx_reg      <= sy - sx;
                    num_neg_reg <= syn;
                end
            end
            S_GDIV:
            begin
                if (dv_fin)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r_fin;
                end
            end
            S_RN: if (dv_fin) num_reg <= dv_q_fin;
            S_RD: if (dv_fin) den_reg <= dv_q_fin;
            S_FIN:
            begin
                if (den_reg > rna_pkg::mag_t'(lim)
                    || num_reg > (rna_pkg::mag_t'(lim) + rna_pkg::mag_t'(num_neg_reg)))
                    st_reg <= rna_pkg::ST_OVF;
            end
            default:
            begin
            end
        endcase
    end

    logic show_val;
    assign show_val = (st_reg == rna_pkg::ST_OK) && (op_reg < rna_pkg::OP_CMP);
    logic [W-1:0] num_w;
    assign num_w = num_neg_reg ? (~num_reg[W-1:0] + 1'b1) : num_reg[W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            res_num    <= show_val ? 32'(signed'(num_w)) : '0;
            res_den    <= show_val ? 31'(den_reg[W-2:0]) : '0;
            is_less    <= lt_reg;
            is_equal   <= eq_reg;
            is_greater <= gt_reg;
            status     <= st_reg;
        end
    end

    assign done = done_reg;
    assign busy = (state_reg != S_IDLE);

    `RNA_ASSERT_IMP(a_done_idle, done, !busy, "result beat while busy")
    `RNA_ASSERT_NXT(a_start_busy, start && !busy, busy, "request not taken")
    `RNA_ASSERT_IMP(a_flags_one, done, $countones({is_less, is_equal, is_greater}) <= 1,
        "more than one compare flag")
    `RNA_ASSERT_IMP(a_ovf_zero, done && status != rna_pkg::ST_OK, res_den == '0,
        "error result carries a value")
endmodule
